FILE: hdl/mvpm_pkg.sv
// ----------------------------------------------------------------------------
// mvpm_pkg
// Shared types and constants for the matrix-vector product block with
// running maximum over row sums.
// ----------------------------------------------------------------------------
`default_nettype none

package mvpm_pkg;

    // default store depth and fixed field widths
    localparam int MAX_DIM_DEF = 1024;
    localparam int CFG_W       = 11;
    localparam int IDX_W       = 10;
    localparam int VAL_W       = 16;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int ACC_W       = 48;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    // register reset values
    localparam logic [CFG_W-1:0] DIM_RST = CFG_W'(1024);

    // register indexes (taken from paddr bit 2)
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    // operation codes of an input beat
    localparam logic OP_VEC_WR = 1'b0;
    localparam logic OP_MATRIX = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_ROW
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic wr_vec;
        logic load;
        logic mul;
        logic acc;
        logic emit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic row_end;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: hdl/mvpm_regs.sv
// ----------------------------------------------------------------------------
// mvpm_regs
// Configuration register file behind a simple APB-style port: column count
// and row count of the product.
// ----------------------------------------------------------------------------
`default_nettype none

module mvpm_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [mvpm_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [mvpm_pkg::DATA_W-1:0]  pwdata,
    output logic      [mvpm_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    output logic      [mvpm_pkg::CFG_W-1:0]   o_cols,
    output logic      [mvpm_pkg::CFG_W-1:0]   o_rows
);
    import mvpm_pkg::*;

    logic [CFG_W-1:0] r_cols;
    logic [CFG_W-1:0] r_rows;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= DIM_RST;
            r_rows <= DIM_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_COLS: r_cols <= pwdata[CFG_W-1:0];
                REG_ROWS: r_rows <= pwdata[CFG_W-1:0];
                default:  r_cols <= r_cols;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_sel)
            REG_COLS: prdata = DATA_W'(r_cols);
            REG_ROWS: prdata = DATA_W'(r_rows);
            default:  prdata = '0;
        endcase
    end

    assign o_cols = r_cols;
    assign o_rows = r_rows;

endmodule

`default_nettype wire

FILE: hdl/mvpm_ctrl.sv
// ----------------------------------------------------------------------------
// mvpm_ctrl
// Controller: accepts input beats, sequences multiply, accumulate and
// row completion, and waits while the output register holds an untaken result.
// ----------------------------------------------------------------------------
`default_nettype none

module mvpm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_operation,
    output logic                   o_in_stall,
    input  wire mvpm_pkg::t_dp_sts i_sts,
    output mvpm_pkg::t_dp_cmd      o_cmd
);
    import mvpm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // input is only taken while idle
    assign accept = i_in_valid && (r_state == ST_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (accept) begin
                    if (i_operation == OP_MATRIX) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_MUL;
                    end else begin
                        o_cmd.wr_vec = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.row_end ? ST_ROW : ST_IDLE;
            end
            ST_ROW: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/mvpm_dp.sv
// ----------------------------------------------------------------------------
// mvpm_dp
// Datapath: vector store, multiplier, row accumulator, running maximum,
// column and row counters and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mvpm_dp #(
    parameter int MAX_DIM = mvpm_pkg::MAX_DIM_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire mvpm_pkg::t_dp_cmd                i_cmd,
    output mvpm_pkg::t_dp_sts                     o_sts,
    input  wire logic [mvpm_pkg::CFG_W-1:0]       i_cols,
    input  wire logic [mvpm_pkg::CFG_W-1:0]       i_rows,
    input  wire logic [mvpm_pkg::IDX_W-1:0]       i_index,
    input  wire logic signed [mvpm_pkg::VAL_W-1:0] i_value,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [mvpm_pkg::IDX_W-1:0]            o_row_index,
    output logic signed [mvpm_pkg::ACC_W-1:0]     o_row_sum,
    output logic signed [mvpm_pkg::ACC_W-1:0]     o_max_so_far,
    output logic                                  o_last
);
    import mvpm_pkg::*;

    localparam int AW = $clog2(MAX_DIM);
    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int EW = (CW > CFG_W) ? CW : CFG_W;

    // vector store
    logic [VAL_W-1:0] mem [MAX_DIM];
    logic [VAL_W-1:0] r_rd_data;

    logic signed [VAL_W-1:0]  r_val;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_max;
    logic signed [ACC_W-1:0]  n_max;
    logic [CW-1:0]            r_col;
    logic [CW-1:0]            r_row;

    logic [EW-1:0] idx_ext;
    logic          idx_ok;
    logic [EW-1:0] cols_ext;
    logic [EW-1:0] rows_ext;
    logic [EW-1:0] eff_cols;
    logic [EW-1:0] eff_rows;
    logic [EW-1:0] col_next;
    logic [EW-1:0] row_next;
    logic          row_end;
    logic          last_row;

    // vector writes beyond the store are dropped
    assign idx_ext = EW'(i_index);
    assign idx_ok  = idx_ext < EW'(MAX_DIM);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_vec && idx_ok) begin
            mem[idx_ext[AW-1:0]] <= i_value;
        end
        r_rd_data <= mem[r_col[AW-1:0]];
    end

    // effective dimensions: zero acts as one, clamp to store depth
    assign cols_ext = EW'(i_cols);
    assign rows_ext = EW'(i_rows);
    assign eff_cols = (cols_ext == '0) ? EW'(1) :
                      (cols_ext > EW'(MAX_DIM)) ? EW'(MAX_DIM) : cols_ext;
    assign eff_rows = (rows_ext == '0) ? EW'(1) :
                      (rows_ext > EW'(MAX_DIM)) ? EW'(MAX_DIM) : rows_ext;

    assign col_next = EW'(r_col) + EW'(1);
    assign row_next = EW'(r_row) + EW'(1);
    assign row_end  = col_next >= eff_cols;
    assign last_row = row_next >= eff_rows;

    // first row of a product always loads the maximum
    assign n_max = ((r_row == '0) || (r_acc > r_max)) ? r_acc : r_max;

    // multiplier operands and product
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val <= i_value;
        end
        if (i_cmd.mul) begin
            r_prod <= r_val * $signed(r_rd_data);
        end
    end

    // accumulator, maximum and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_max <= '0;
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.acc) begin
            r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
            if (!row_end) begin
                r_col <= col_next[CW-1:0];
            end
        end else if (i_cmd.emit) begin
            r_max <= n_max;
            r_acc <= '0;
            r_col <= '0;
            r_row <= last_row ? '0 : row_next[CW-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_row_index  <= IDX_W'(r_row);
            o_row_sum    <= r_acc;
            o_max_so_far <= n_max;
            o_last       <= last_row;
        end
    end

    assign o_sts.row_end  = row_end;
    assign o_sts.out_free = !o_out_valid || !i_out_stall;

endmodule

`default_nettype wire

FILE: hdl/matrix_vector_product_max.sv
// A matrix beat ending a row reaches the output register through the multiply,
// accumulate and row states. A vector write leaves the input free; a matrix beat
// stalls it through the store read, registered multiply and 48-bit accumulate.
// A row end waits further while the output register holds an untaken result.
// Reset (synchronous, active low) clears counters, accumulator, maximum, state and
// output valid; registers return to 1024; the vector store is undefined until written.
// ----------------------------------------------------------------------------
// matrix_vector_product_max
// Matrix-vector product in Q8.8 with per-row Q32.16 sums and a running maximum
// over the finished rows of the current product.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_vector_product_max #(
    parameter int MAX_DIM = mvpm_pkg::MAX_DIM_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_operation,
    input  wire logic [mvpm_pkg::IDX_W-1:0]        i_index,
    input  wire logic signed [mvpm_pkg::VAL_W-1:0] i_value,
    // output channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [mvpm_pkg::IDX_W-1:0]             o_row_index,
    output logic signed [mvpm_pkg::ACC_W-1:0]      o_row_sum,
    output logic signed [mvpm_pkg::ACC_W-1:0]      o_max_so_far,
    output logic                                   o_last,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mvpm_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [mvpm_pkg::DATA_W-1:0]       pwdata,
    output logic      [mvpm_pkg::DATA_W-1:0]       prdata,
    output logic                                   pready
);
    import mvpm_pkg::*;

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic [CFG_W-1:0] cols;
    logic [CFG_W-1:0] rows;

    // configuration registers
    mvpm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cols  (cols),
        .o_rows  (rows)
    );

    // controller
    mvpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_stall  (o_in_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath
    mvpm_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cols       (cols),
        .i_rows       (rows),
        .i_index      (i_index),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_row_index  (o_row_index),
        .o_row_sum    (o_row_sum),
        .o_max_so_far (o_max_so_far),
        .o_last       (o_last)
    );

    // a matrix beat keeps the block busy for the following cycle
    a_matrix_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_operation == OP_MATRIX)) |=> o_in_stall)
        else $error("input not stalled after matrix beat");

    // after a vector write the input is free again in the next cycle
    a_vec_wr_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_operation == OP_VEC_WR)) |=> !o_in_stall)
        else $error("input stalled after vector write");

    // the reported maximum never falls below the row sum it comes with
    a_max_ge_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_max_so_far >= o_row_sum))
        else $error("running maximum below row sum");

    // a new result only appears after the block was busy
    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without prior work");

endmodule

`default_nettype wire

FILE: verif/mvpm_row_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mvpm_row_checker
// Watches the input, output and register channels of the matrix-vector
// product block, keeps its own copy of the vector store, counters and running
// maximum, and checks every row result against the predicted one in order.
// ----------------------------------------------------------------------------

module mvpm_row_checker #(
    parameter int MAX_DIM = mvpm_pkg::MAX_DIM_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input channel
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_stall,
    input  wire logic                              i_operation,
    input  wire logic [mvpm_pkg::IDX_W-1:0]        i_index,
    input  wire logic signed [mvpm_pkg::VAL_W-1:0] i_value,
    // output channel
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_stall,
    input  wire logic [mvpm_pkg::IDX_W-1:0]        i_row_index,
    input  wire logic signed [mvpm_pkg::ACC_W-1:0] i_row_sum,
    input  wire logic signed [mvpm_pkg::ACC_W-1:0] i_max_so_far,
    input  wire logic                              i_last,
    // register port
    input  wire logic                              i_psel,
    input  wire logic                              i_penable,
    input  wire logic                              i_pwrite,
    input  wire logic                              i_pready,
    input  wire logic [mvpm_pkg::ADDR_W-1:0]       i_paddr,
    input  wire logic [mvpm_pkg::DATA_W-1:0]       i_pwdata,
    // status to the test top
    output int                                     o_err_cnt,
    output int                                     o_pending,
    output int                                     o_rows_seen
);

    import mvpm_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic signed [ACC_W-1:0] sum;
        logic signed [ACC_W-1:0] peak;
        logic                    last;
    } t_row_result;

    // shadow of the block state
    logic signed [VAL_W-1:0] vec_mem [MAX_DIM];
    int unsigned             col_cnt;
    int unsigned             row_cnt;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] run_max;
    logic [CFG_W-1:0]        cols_reg;
    logic [CFG_W-1:0]        rows_reg;

    t_row_result rows_due [$];
    int          err_cnt   = 0;
    int          rows_seen = 0;

    // register value 0 acts as 1, values above the store depth clip to it
    function automatic int unsigned dim_limit(input logic [CFG_W-1:0] r);
        if (r == '0)
            return 1;
        if (int'(r) > MAX_DIM)
            return MAX_DIM;
        return r;
    endfunction

    // one accepted beat: store write, or multiply-accumulate with row close-out
    task automatic step_product(input logic op, input logic [IDX_W-1:0] idx,
                                input logic signed [VAL_W-1:0] val);
        logic signed [PROD_W-1:0] prod;
        t_row_result              res;
        logic                     is_last;
        if (op == OP_VEC_WR) begin
            if (int'(idx) < MAX_DIM)
                vec_mem[idx] = val;
        end else begin
            prod = val * vec_mem[col_cnt % MAX_DIM];
            acc  = acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
            col_cnt++;
            if (col_cnt >= dim_limit(cols_reg)) begin
                if (row_cnt == 0 || acc > run_max)
                    run_max = acc;
                is_last  = (row_cnt + 1 >= dim_limit(rows_reg));
                res.row  = IDX_W'(row_cnt);
                res.sum  = acc;
                res.peak = run_max;
                res.last = is_last;
                rows_due.push_back(res);
                acc     = '0;
                col_cnt = 0;
                row_cnt = is_last ? 0 : row_cnt + 1;
            end
        end
    endtask

    always @(posedge i_clk) begin : track
        t_row_result want;
        if (!i_rst_n) begin
            col_cnt  = 0;
            row_cnt  = 0;
            acc      = '0;
            run_max  = '0;
            cols_reg = DIM_RST;
            rows_reg = DIM_RST;
            rows_due.delete();
        end else begin
            // result beat against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                rows_seen++;
                if (rows_due.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: unexpected row beat: row %0d sum %0d max %0d last %0b",
                                 $time, i_row_index, i_row_sum, i_max_so_far, i_last);
                end else begin
                    want = rows_due.pop_front();
                    if (i_row_index != want.row || i_row_sum != want.sum
                            || i_max_so_far != want.peak || i_last != want.last) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("%0t: row beat mismatch", $time);
                            $display("  expected row %0d sum %0d max %0d last %0b",
                                     want.row, $signed(want.sum), $signed(want.peak),
                                     want.last);
                            $display("  actual   row %0d sum %0d max %0d last %0b",
                                     i_row_index, i_row_sum, i_max_so_far, i_last);
                        end
                    end
                end
            end
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[2])
                    REG_COLS: cols_reg = i_pwdata[CFG_W-1:0];
                    REG_ROWS: rows_reg = i_pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
            // input beat
            if (i_in_valid && !i_in_stall)
                step_product(i_operation, i_index, i_value);
        end
        o_pending   <= rows_due.size();
        o_err_cnt   <= err_cnt;
        o_rows_seen <= rows_seen;
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the matrix-vector product block: directed corner
// products, a clipped row length, a 1024-row product with a long output
// hold-off, then random products with random register settings, bursty input
// and random stalls.
// ----------------------------------------------------------------------------

module tb_top;

    import mvpm_pkg::*;

    localparam int DIM            = MAX_DIM_DEF;
    localparam int SETTLE_CYCLES  = 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_BEATS   = 350;
    localparam int PHASE_CAP      = 150;

    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    // block inputs, known from time zero
    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    i_operation = OP_VEC_WR;
    logic [IDX_W-1:0]        i_index     = '0;
    logic signed [VAL_W-1:0] i_value     = '0;
    logic                    i_out_stall = 1'b0;
    logic                    psel        = 1'b0;
    logic                    penable     = 1'b0;
    logic                    pwrite      = 1'b0;
    logic [ADDR_W-1:0]       paddr       = '0;
    logic [DATA_W-1:0]       pwdata      = '0;

    // block outputs
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic [IDX_W-1:0]        o_row_index;
    logic signed [ACC_W-1:0] o_row_sum;
    logic signed [ACC_W-1:0] o_max_so_far;
    logic                    o_last;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;

    // checker status
    int mismatch_cnt;
    int rows_pending;
    int rows_seen;

    // stimulus bookkeeping
    bit          written [DIM];
    int unsigned cols_now    = DIM;
    int unsigned rows_now    = DIM;
    int          beats_sent  = 0;
    int          vec_writes  = 0;
    int          reg_writes  = 0;
    int          burst_left  = 0;
    bit          gaps_on     = 1'b1;
    bit          hold_req    = 1'b0;
    bit          hold_done   = 1'b0;

    matrix_vector_product_max #(
        .MAX_DIM (DIM)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_index      (i_index),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_row_index  (o_row_index),
        .o_row_sum    (o_row_sum),
        .o_max_so_far (o_max_so_far),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    mvpm_row_checker #(
        .MAX_DIM (DIM)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_index      (i_index),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_row_index  (o_row_index),
        .i_row_sum    (o_row_sum),
        .i_max_so_far (o_max_so_far),
        .i_last       (o_last),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_err_cnt    (mismatch_cnt),
        .o_pending    (rows_pending),
        .o_rows_seen  (rows_seen)
    );

    // 100 MHz clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned dim_of(input logic [CFG_W-1:0] r);
        if (r == '0)
            return 1;
        return (int'(r) > DIM) ? DIM : r;
    endfunction

    // mostly random, with the field extremes now and then
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            default: return VAL_W'($urandom());
        endcase
    endfunction

    // biased to the extremes to push the sums toward their widest
    function automatic logic signed [VAL_W-1:0] heavy_value();
        case ($urandom_range(0, 3))
            0, 1: return VAL_MIN;
            2: return VAL_MAX;
            default: return VAL_W'($urandom());
        endcase
    endfunction

    // one input beat, with random gaps between bursts
    task automatic send_beat(input logic op, input logic [IDX_W-1:0] idx,
                             input logic signed [VAL_W-1:0] val);
        if (burst_left == 0) begin
            if (gaps_on && $urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_index     <= idx;
        i_value     <= val;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall)
                break;
        end
        beats_sent++;
        if (op == OP_VEC_WR) begin
            written[idx] = 1'b1;
            vec_writes++;
        end
    endtask

    task automatic send_elem(input logic signed [VAL_W-1:0] val);
        send_beat(OP_MATRIX, IDX_W'($urandom()), val);
    endtask

    // drop valid, drain all expected rows, then let in-flight beats finish
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        forever begin
            @(posedge i_clk);
            if (rows_pending == 0)
                break;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // setup then access; psel stays up so writes can go back to back
    task automatic reg_write(input logic sel, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= ($urandom_range(0, 1) ? ($urandom() & ~32'h7ff) : '0) | DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready)
                break;
        end
        reg_writes++;
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] r);
        wait_idle();
        reg_write(REG_COLS, c);
        reg_write(REG_ROWS, r);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cols_now = dim_of(c);
        rows_now = dim_of(r);
    endtask

    // every column in use must hold a written entry before matrix beats read it
    task automatic load_vector(input bit heavy);
        for (int i = 0; i < cols_now; i++) begin
            if (!written[i] || (cols_now <= 64 && $urandom_range(0, 2) == 0))
                send_beat(OP_VEC_WR, IDX_W'(i), heavy ? heavy_value() : pick_value());
        end
    endtask

    // n matrix beats, optionally with stray vector writes mixed in
    task automatic run_matrix(input int n, input bit heavy, input bit noise);
        int sent;
        sent = 0;
        while (sent < n) begin
            if (noise && $urandom_range(0, 9) == 0) begin
                send_beat(OP_VEC_WR, IDX_W'($urandom()), pick_value());
            end else begin
                send_elem(heavy ? heavy_value() : pick_value());
                sent++;
            end
        end
    endtask

    // output stall pattern, plus one long hold-off on request
    initial begin : rx_pattern
        t_rx_mode mode;
        int       seg;
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            mode = t_rx_mode'($urandom_range(0, 3));
            seg  = $urandom_range(10, 150);
            for (int n = 0; n < seg && !(hold_req && !hold_done); n++) begin
                case (mode)
                    RX_OPEN:     i_out_stall <= 1'b0;
                    RX_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY:    i_out_stall <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: i_out_stall <= (n % 5 < 2);
                    default:     i_out_stall <= 1'b0;
                endcase
                @(posedge i_clk);
            end
        end
    end

    // end the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (psel && penable && pwrite && pready) || !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no beat moved for %0d cycles, %0d rows outstanding",
                 quiet, rows_pending);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        int               start_cnt;
        int               n;
        logic [CFG_W-1:0] c;
        logic [CFG_W-1:0] r;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes of the vector and matrix fields
        set_dims(4, 3);
        send_beat(OP_VEC_WR, 0, VAL_MIN);
        send_beat(OP_VEC_WR, 0, VAL_MAX);
        send_beat(OP_VEC_WR, 1, VAL_MIN);
        send_beat(OP_VEC_WR, 2, -16'sd1);
        send_beat(OP_VEC_WR, 3, 16'sd256);
        send_beat(OP_VEC_WR, {IDX_W{1'b1}}, 16'sh5a5a);
        // full product: big first row, small second, bigger third
        send_elem(VAL_MAX); send_elem(VAL_MIN); send_elem('0);     send_elem(16'sd1);
        send_elem(16'sd1);  send_elem(16'sd1);  send_elem(16'sd1); send_elem(16'sd1);
        send_elem(VAL_MAX); send_elem(VAL_MIN); send_elem(VAL_MIN); send_elem(VAL_MAX);
        // new product with a negative first row: maximum restarts from it
        send_elem(VAL_MIN); send_elem(VAL_MAX); send_elem(VAL_MAX); send_elem(VAL_MIN);
        // shrink the row length mid-row: the next beat closes the row
        send_elem(16'sd5);  send_elem(16'sd6);
        set_dims(2, 3);
        send_elem(16'sd7);
        // row count of zero acts as one, already passed: next row is last
        set_dims(2, 0);
        send_elem(-16'sd3); send_elem(16'sd9);

        // register above the store depth clips to it: row stays open
        set_dims(11'd2047, 1);
        gaps_on = 1'b1;
        run_matrix(3, 1'b1, 1'b0);

        // most rows, one column each; the first beat closes the open row,
        // long output hold-off in the middle
        set_dims(0, DIM);
        gaps_on = 1'b0;
        run_matrix(20, 1'b0, 1'b0);
        hold_req = 1'b1;
        run_matrix(DIM - 20, 1'b0, 1'b0);

        // random products with random register settings
        start_cnt = beats_sent;
        while (beats_sent - start_cnt < RANDOM_BEATS) begin
            case ($urandom_range(0, 19))
                0:       c = '0;
                1:       c = CFG_W'($urandom_range(49, 64));
                2, 3, 4: c = CFG_W'($urandom_range(9, 48));
                default: c = CFG_W'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 19))
                0:       r = '0;
                1:       r = CFG_W'($urandom_range(DIM, 2047));
                2, 3, 4: r = CFG_W'($urandom_range(7, 30));
                default: r = CFG_W'($urandom_range(1, 6));
            endcase
            set_dims(c, r);
            gaps_on = ($urandom_range(0, 3) != 0);
            load_vector(1'b0);
            n = cols_now * rows_now;
            if ($urandom_range(0, 3) == 0)
                n = $urandom_range(1, n);
            if (n > PHASE_CAP)
                n = $urandom_range(1, PHASE_CAP);
            run_matrix(n, $urandom_range(0, 7) == 0, 1'b1);
        end

        wait_idle();
        $display("covered %0d input beats (%0d vector writes) and %0d register writes",
                 beats_sent, vec_writes, reg_writes);
        $display("checked %0d row results, products of up to 1024 rows, clipped registers",
                 rows_seen);
        if (mismatch_cnt == 0 && rows_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: files.f
hdl/mvpm_pkg.sv
hdl/mvpm_regs.sv
hdl/mvpm_ctrl.sv
hdl/mvpm_dp.sv
hdl/matrix_vector_product_max.sv
verif/mvpm_row_checker.sv
verif/tb_top.sv
